>>> rtl/nearest_palette_color_assert.svh
// assertion macros for the palette block
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npc same-cycle check failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npc next-cycle check failed");

`endif

>>> rtl/npc_pkg.sv
`default_nettype none

package npc_pkg;

  localparam int COUNT_W = 9;
  localparam int DIST_W  = 18;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_NEAREST = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [DIST_W-1:0] W_RED   = DIST_W'(299);
  localparam logic [DIST_W-1:0] W_GREEN = DIST_W'(587);
  localparam logic [DIST_W-1:0] W_BLUE  = DIST_W'(114);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic [7:0] found_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       ok;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

>>> rtl/nearest_palette_color.sv
// nearest_palette_color: palette store with weighted nearest-colour search
//
// in channel (in_valid/in_ready/in_data) takes one item per beat: write an
// entry, find the nearest entry to a colour, or read an entry back. every
// item gives exactly one result beat on the out channel
// (out_valid/out_ready/out_data). cfg channel (cfg_valid/cfg_ready/cfg_data)
// sets the entry count and is always ready.
// one item is in flight at a time. a write, an unknown op, an out of range
// read or a nearest on an empty palette goes straight to the hold state; a
// read first passes the read state and a nearest search the scan state. the
// result beat leaves from the hold state; the next item is taken back in idle.
// a search streams one entry per cycle from the single memory read port
// through a registered distance stage and a compare stage.
// the result sits in a pending register, then moves to the output register;
// the next item is accepted while that output beat still waits. a stalled
// receiver holds the block in its hold state once a second result is ready.
// reset clears the entry count and all handshake state; palette contents are
// undefined until written and need no clearing pass.
`default_nettype none

module nearest_palette_color #(
  parameter int ENTRIES = 256
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [npc_pkg::COUNT_W-1:0]     cfg_data,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  npc_pkg::item_t                  in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output npc_pkg::result_t                out_data
);

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = ($clog2(ENTRIES + 1) > npc_pkg::COUNT_W) ?
                        $clog2(ENTRIES + 1) : npc_pkg::COUNT_W;
  localparam logic [CNTW-1:0] ENT = CNTW'(ENTRIES);

  npc_pkg::rgb_t                mem [ENTRIES];
  npc_pkg::rgb_t                rd_data;
  logic                         mem_we;
  logic                         mem_re;
  logic [AW-1:0]                mem_addr;
  npc_pkg::rgb_t                wr_data;

  npc_pkg::state_t              state;
  npc_pkg::state_t              state_next;
  logic [npc_pkg::COUNT_W-1:0]  entry_count;
  logic [CNTW-1:0]              eff_count;
  logic [CNTW-1:0]              idx_ext;
  logic                         in_fire;
  logic                         out_free;
  npc_pkg::item_t               item;
  npc_pkg::rgb_t                target;
  npc_pkg::result_t             res;

  logic [CNTW-1:0]              scan_addr;
  logic                         rd_valid;
  logic [AW-1:0]                rd_idx;
  logic                         dist_valid;
  logic [AW-1:0]                dist_idx;
  logic [npc_pkg::DIST_W-1:0]   distance;
  logic                         have;
  logic [npc_pkg::DIST_W-1:0]   best_d;
  logic [AW-1:0]                best_idx;
  logic                         scan_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == npc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign idx_ext   = CNTW'(in_data.index);
  assign eff_count = (CNTW'(entry_count) > ENT) ? ENT : CNTW'(entry_count);
  assign scan_done = (scan_addr == eff_count) && !rd_valid && !dist_valid;
  assign target    = '{red: item.red, green: item.green, blue: item.blue};
  assign wr_data   = '{red: in_data.red, green: in_data.green, blue: in_data.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // palette memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      npc_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.op)
            npc_pkg::OP_NEAREST: begin
              state_next = (eff_count == '0) ? npc_pkg::ST_HOLD : npc_pkg::ST_SCAN;
            end
            npc_pkg::OP_READ: begin
              state_next = (idx_ext < eff_count) ? npc_pkg::ST_READ : npc_pkg::ST_HOLD;
            end
            default: begin
              state_next = npc_pkg::ST_HOLD;
            end
          endcase
        end
      end
      npc_pkg::ST_READ: begin
        state_next = npc_pkg::ST_HOLD;
      end
      npc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = npc_pkg::ST_HOLD;
        end
      end
      npc_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = npc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = npc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = AW'(in_data.index);
    case (state)
      npc_pkg::ST_IDLE: begin
        mem_we = in_fire && (in_data.op == npc_pkg::OP_WRITE) && (idx_ext < ENT);
        mem_re = in_fire && (in_data.op == npc_pkg::OP_READ) && (idx_ext < eff_count);
      end
      npc_pkg::ST_SCAN: begin
        mem_re   = (scan_addr < eff_count);
        mem_addr = scan_addr[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  npc_dist #(
    .AW (AW)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (rd_valid),
    .entry_idx   (rd_idx),
    .entry       (rd_data),
    .target      (target),
    .dist_valid  (dist_valid),
    .dist_idx    (dist_idx),
    .distance    (distance)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      have      <= 1'b0;
      scan_addr <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == npc_pkg::ST_SCAN) && mem_re;
      if (in_fire) begin
        scan_addr <= '0;
        have      <= 1'b0;
      end else if ((state == npc_pkg::ST_SCAN) && mem_re) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (dist_valid && (!have || (distance < best_d))) begin
        have <= 1'b1;
      end
      if ((state == npc_pkg::ST_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= mem_addr;
    if (in_fire) begin
      item                <= in_data;
      res.found_index     <= (in_data.op == npc_pkg::OP_NEAREST) ? 8'd0 : in_data.index;
      res.out_red         <= 8'd0;
      res.out_green       <= 8'd0;
      res.out_blue        <= 8'd0;
      res.ok              <= (in_data.op == npc_pkg::OP_WRITE) ||
                             (in_data.op == npc_pkg::OP_NEAREST) ||
                             ((in_data.op == npc_pkg::OP_READ) && (idx_ext < eff_count));
    end else if (state == npc_pkg::ST_READ) begin
      res.out_red   <= rd_data.red;
      res.out_green <= rd_data.green;
      res.out_blue  <= rd_data.blue;
    end else if ((state == npc_pkg::ST_SCAN) && scan_done) begin
      res.found_index <= 8'(best_idx);
    end
    if (dist_valid && (!have || (distance < best_d))) begin
      best_d   <= distance;
      best_idx <= dist_idx;
    end
    if ((state == npc_pkg::ST_HOLD) && out_free) begin
      out_data <= res;
    end
  end

`include "nearest_palette_color_assert.svh"

  `NPC_ASSERT_NEXT(a_scan_start, in_fire && (in_data.op == npc_pkg::OP_NEAREST) && (eff_count != '0), state == npc_pkg::ST_SCAN)
  `NPC_ASSERT_IMPL(a_scan_bound, state == npc_pkg::ST_SCAN, scan_addr <= eff_count)
  `NPC_ASSERT_IMPL(a_best_in_range, (state == npc_pkg::ST_SCAN) && have, CNTW'(best_idx) < eff_count)

endmodule

`default_nettype wire

>>> rtl/npc_dist.sv
`default_nettype none

module npc_dist #(
  parameter int AW = 8
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               entry_valid,
  input  wire  [AW-1:0]                     entry_idx,
  input  npc_pkg::rgb_t                     entry,
  input  npc_pkg::rgb_t                     target,
  output logic                              dist_valid,
  output logic [AW-1:0]                     dist_idx,
  output logic [npc_pkg::DIST_W-1:0]        distance
);

  logic [7:0]                   dr;
  logic [7:0]                   dg;
  logic [7:0]                   db;
  logic [npc_pkg::DIST_W-1:0]   dist_next;

  always_comb begin
    dr = (entry.red   > target.red)   ? entry.red   - target.red   : target.red   - entry.red;
    dg = (entry.green > target.green) ? entry.green - target.green : target.green - entry.green;
    db = (entry.blue  > target.blue)  ? entry.blue  - target.blue  : target.blue  - entry.blue;
    dist_next = npc_pkg::W_RED   * npc_pkg::DIST_W'(dr)
              + npc_pkg::W_GREEN * npc_pkg::DIST_W'(dg)
              + npc_pkg::W_BLUE  * npc_pkg::DIST_W'(db);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else begin
      dist_valid <= entry_valid;
    end
    dist_idx <= entry_idx;
    distance <= dist_next;
  end

endmodule

`default_nettype wire
